// ===== hdl/saff_pkg.sv =====
// Package for the stereo audio frame FIFO: item structs, command and status codes.
// No dependencies; the top level and the testbench import it.
`timescale 1ns / 1ps

package saff_pkg;

    // Command codes carried in the command field of an input item.
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // Transfer status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

    localparam int SAMPLE_W = 16;
    localparam int TALLY_W  = 16;
    localparam int FILL_W   = 11;
    localparam int CAP_CFG_W = 11;

    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

    typedef struct packed {
        logic                       command;
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
        logic                       last_of_transfer;
    } t_frame_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_left;
        logic signed [SAMPLE_W-1:0] out_right;
        logic                       frame_accepted;
        logic                       frame_dropped;
        logic        [TALLY_W-1:0]  call_accepted;
        logic        [TALLY_W-1:0]  call_dropped;
        logic        [1:0]          status;
        logic        [FILL_W-1:0]   fill_level;
        logic                       is_last;
    } t_frame_out;

endpackage

// ===== hdl/saff_ram.sv =====
// Generic single-port RAM with registered read data, used for the frame store.
// No dependencies.
`timescale 1ns / 1ps

module saff_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                       i_wdata,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/stereo_audio_frame_fifo.sv =====
// Top level of the stereo audio frame FIFO: ring control, transfer tallies, result register.
// Depends on saff_pkg and on saff_ram for the frame store.
`timescale 1ns / 1ps

// The FIFO takes one push or pop item in every clock cycle: busy is always low, and an
// item is accepted whenever start is high. Each item gives exactly one result, which
// appears on o_result with o_result_valid high for one cycle, the cycle after the item
// was accepted. The receiver cannot stall, so it must take every result as it comes.
// Results are registered; popped samples come from the frame store RAM's read register; the
// control decisions are made in the accepting cycle from the pointer and occupancy
// registers, so back-to-back items, including a pop straight after a push, see each
// other's effects. Writing the capacity register empties the queue but leaves the
// transfer tallies alone; it should only be written while no item is in flight. The
// frame store itself is never cleared, since a slot is always written before it is read.
module stereo_audio_frame_fifo #(
    parameter int DEPTH = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  saff_pkg::t_frame_in                   i_frame,
    output logic                                  o_result_valid,
    output saff_pkg::t_frame_out                  o_result,
    input  logic                                  i_cap_we,
    input  logic [saff_pkg::CAP_CFG_W-1:0]        i_cap_wdata
);

    import saff_pkg::*;

    // Pointer and occupancy widths follow from the depth of the ring.
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CAP_W = $clog2(DEPTH + 1);
    localparam int CAP_RESET_INT = (DEPTH < 1024) ? DEPTH : 1024;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(CAP_RESET_INT);
    localparam logic [CAP_W-1:0] CAP_DEPTH = CAP_W'(DEPTH);

    // Control state of the ring and of the current transfer.
    logic [CAP_W-1:0]   r_capacity,  n_capacity;
    logic [PTR_W-1:0]   r_rd_ptr,    n_rd_ptr;
    logic [PTR_W-1:0]   r_wr_ptr,    n_wr_ptr;
    logic [CAP_W-1:0]   r_occupancy, n_occupancy;
    logic [TALLY_W-1:0] r_acc_tally, n_acc_tally;
    logic [TALLY_W-1:0] r_drop_tally, n_drop_tally;

    // Result register; the popped samples come straight from the RAM's read register.
    logic               r_valid;
    t_frame_out         r_result,    n_result;
    logic               r_pop_ok,    n_pop_ok;

    logic               accept;
    logic               is_pop;
    logic               push_ok;
    logic               pop_ok;
    logic               item_ok;
    logic [TALLY_W-1:0] acc_upd;
    logic [TALLY_W-1:0] drop_upd;
    logic [CAP_W-1:0]   cap_clamped;
    logic [CAP_W-1:0]   rd_next;
    logic [CAP_W-1:0]   wr_next;
    logic [CAP_W-1:0]   occ_upd;

    logic               ram_en;
    logic               ram_we;
    logic [PTR_W-1:0]   ram_addr;
    logic [31:0]        ram_wdata;
    logic [31:0]        ram_rdata;

    // The FIFO never holds an item back.
    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign is_pop = (i_frame.command == CMD_POP);

    // A pop needs a frame in the queue; a push needs a free slot within the capacity.
    assign pop_ok  = is_pop && (r_occupancy != '0);
    assign push_ok = !is_pop && (r_occupancy < r_capacity);
    assign item_ok = pop_ok || push_ok;

    // Written capacity: zero counts as one and anything above the depth as the depth.
    always_comb begin
        if (i_cap_wdata == '0) begin
            cap_clamped = CAP_W'(1);
        end else if (int'(i_cap_wdata) > DEPTH) begin
            cap_clamped = CAP_DEPTH;
        end else begin
            cap_clamped = CAP_W'(i_cap_wdata);
        end
    end

    // Each pointer wraps to zero once it reaches the capacity.
    always_comb begin
        rd_next = CAP_W'(r_rd_ptr) + CAP_W'(1);
        if (rd_next >= r_capacity) begin
            rd_next = '0;
        end
        wr_next = CAP_W'(r_wr_ptr) + CAP_W'(1);
        if (wr_next >= r_capacity) begin
            wr_next = '0;
        end
    end

    // Saturating transfer tallies, including the current item.
    assign acc_upd  = (item_ok && r_acc_tally != TALLY_MAX) ? r_acc_tally + 1'b1
                                                              : r_acc_tally;
    assign drop_upd = (!item_ok && r_drop_tally != TALLY_MAX) ? r_drop_tally + 1'b1
                                                                : r_drop_tally;

    always_comb begin
        occ_upd = r_occupancy;
        if (pop_ok) begin
            occ_upd = r_occupancy - 1'b1;
        end else if (push_ok) begin
            occ_upd = r_occupancy + 1'b1;
        end
    end

    always_comb begin
        n_capacity   = r_capacity;
        n_rd_ptr     = r_rd_ptr;
        n_wr_ptr     = r_wr_ptr;
        n_occupancy  = r_occupancy;
        n_acc_tally  = r_acc_tally;
        n_drop_tally = r_drop_tally;

        n_pop_ok = pop_ok;
        n_result.out_left       = '0;
        n_result.out_right      = '0;
        n_result.frame_accepted = item_ok;
        n_result.frame_dropped  = !item_ok;
        n_result.call_accepted  = acc_upd;
        n_result.call_dropped   = drop_upd;
        if (drop_upd == '0) begin
            n_result.status = STATUS_OK;
        end else if (is_pop) begin
            n_result.status = STATUS_UNDERFLOW;
        end else begin
            n_result.status = STATUS_FULL;
        end
        n_result.fill_level = FILL_W'(occ_upd);
        n_result.is_last    = i_frame.last_of_transfer;

        if (i_cap_we) begin
            // A capacity write empties the queue; the tallies carry on.
            n_capacity  = cap_clamped;
            n_rd_ptr    = '0;
            n_wr_ptr    = '0;
            n_occupancy = '0;
        end else if (accept) begin
            if (pop_ok) begin
                n_rd_ptr = PTR_W'(rd_next);
            end
            if (push_ok) begin
                n_wr_ptr = PTR_W'(wr_next);
            end
            n_occupancy = occ_upd;
            // The last item of a transfer closes it, so the tallies start afresh.
            if (i_frame.last_of_transfer) begin
                n_acc_tally  = '0;
                n_drop_tally = '0;
            end else begin
                n_acc_tally  = acc_upd;
                n_drop_tally = drop_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity   <= CAP_RESET;
            r_rd_ptr     <= '0;
            r_wr_ptr     <= '0;
            r_occupancy  <= '0;
            r_acc_tally  <= '0;
            r_drop_tally <= '0;
            r_valid      <= 1'b0;
        end else begin
            r_capacity   <= n_capacity;
            r_rd_ptr     <= n_rd_ptr;
            r_wr_ptr     <= n_wr_ptr;
            r_occupancy  <= n_occupancy;
            r_acc_tally  <= n_acc_tally;
            r_drop_tally <= n_drop_tally;
            r_valid      <= accept && !i_cap_we;
        end
    end

    // Payload of the result register needs no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
            r_pop_ok <= n_pop_ok;
        end
    end

    // The frame store is read on a successful pop and written on a successful push.
    // The left sample sits in the low half of each word.
    assign ram_en    = accept && !i_cap_we && item_ok;
    assign ram_we    = push_ok;
    assign ram_addr  = is_pop ? r_rd_ptr : r_wr_ptr;
    assign ram_wdata = {i_frame.right_sample, i_frame.left_sample};

    saff_ram #(
        .WIDTH(32),
        .DEPTH(DEPTH)
    ) u_frame_store (
        .i_clk  (i_clk),
        .i_en   (ram_en),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    // Popped samples are taken from the RAM read register; pushes and underflows give silence.
    always_comb begin
        o_result = r_result;
        if (r_pop_ok) begin
            o_result.out_left  = ram_rdata[SAMPLE_W-1:0];
            o_result.out_right = ram_rdata[2*SAMPLE_W-1:SAMPLE_W];
        end
    end

    assign o_result_valid = r_valid;

endmodule

// ===== verif/tb_stereo_audio_frame_fifo.sv =====
// Self-checking testbench for the stereo audio frame FIFO (stereo_audio_frame_fifo).
// Depends on saff_pkg for the item structs and codes, and on the RTL of the block.
`timescale 1ns / 1ps

module tb_stereo_audio_frame_fifo;

    import saff_pkg::*;

    localparam int DEPTH          = 1024;
    localparam int RESET_CYCLES   = 6;
    localparam int RESULT_LATENCY = 1;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int MAX_REPORTS    = 10;

    // Predictor of the ring queue. It keeps its own copy of the frame store, pointers,
    // occupancy, capacity and transfer tallies, and holds the results still awaited.
    class frame_fifo_predictor;
        logic [31:0]        frame_store [DEPTH];
        int unsigned        capacity;
        int unsigned        rd_ptr;
        int unsigned        wr_ptr;
        int unsigned        occupancy;
        logic [TALLY_W-1:0] accepted_tally;
        logic [TALLY_W-1:0] dropped_tally;
        t_frame_out         awaited_results [$];
        int                 failures;

        function new();
            capacity       = DEPTH;
            rd_ptr         = 0;
            wr_ptr         = 0;
            occupancy      = 0;
            accepted_tally = '0;
            dropped_tally  = '0;
            failures       = 0;
        endfunction

        // A capacity write clamps to 1..DEPTH and empties the queue; tallies are kept.
        function void set_capacity(logic [CAP_CFG_W-1:0] value);
            if (value == 0)
                capacity = 1;
            else if (value > DEPTH)
                capacity = DEPTH;
            else
                capacity = 32'(value);
            rd_ptr    = 0;
            wr_ptr    = 0;
            occupancy = 0;
        endfunction

        function int unsigned step_ptr(int unsigned p);
            return (p + 1 >= capacity) ? 0 : p + 1;
        endfunction

        function void predict_frame(t_frame_in f);
            t_frame_out e;
            logic       took;
            e    = '0;
            took = 1'b0;
            if (f.command == CMD_POP) begin
                if (occupancy != 0) begin
                    {e.out_right, e.out_left} = frame_store[rd_ptr];
                    rd_ptr = step_ptr(rd_ptr);
                    occupancy--;
                    took = 1'b1;
                end
            end else if (occupancy < capacity) begin
                frame_store[wr_ptr] = {f.right_sample, f.left_sample};
                wr_ptr = step_ptr(wr_ptr);
                occupancy++;
                took = 1'b1;
            end
            if (took) begin
                if (accepted_tally != TALLY_MAX) accepted_tally++;
            end else begin
                if (dropped_tally != TALLY_MAX) dropped_tally++;
            end
            e.frame_accepted = took;
            e.frame_dropped  = !took;
            e.call_accepted  = accepted_tally;
            e.call_dropped   = dropped_tally;
            if (dropped_tally == 0)
                e.status = STATUS_OK;
            else
                e.status = (f.command == CMD_POP) ? STATUS_UNDERFLOW : STATUS_FULL;
            e.fill_level = FILL_W'(occupancy);
            e.is_last    = f.last_of_transfer;
            awaited_results.push_back(e);
            if (f.last_of_transfer) begin
                accepted_tally = '0;
                dropped_tally  = '0;
            end
        endfunction

        function string describe(t_frame_out r);
            return $sformatf("L=%0d R=%0d acc=%b drop=%b ca=%0d cd=%0d st=%0d fill=%0d last=%b",
                             r.out_left, r.out_right, r.frame_accepted, r.frame_dropped,
                             r.call_accepted, r.call_dropped, r.status, r.fill_level,
                             r.is_last);
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= MAX_REPORTS)
                $display("[%0t] %s", $realtime, msg);
        endfunction

        function void check_result(t_frame_out got);
            t_frame_out e;
            if (awaited_results.size() == 0) begin
                note_failure({"result with no item outstanding: ", describe(got)});
                return;
            end
            e = awaited_results.pop_front();
            if (got.out_left !== e.out_left || got.out_right !== e.out_right ||
                got.frame_accepted !== e.frame_accepted ||
                got.frame_dropped !== e.frame_dropped ||
                got.call_accepted !== e.call_accepted ||
                got.call_dropped !== e.call_dropped || got.status !== e.status ||
                got.fill_level !== e.fill_level || got.is_last !== e.is_last)
                note_failure({"mismatch: expected ", describe(e), " got ", describe(got)});
        endfunction
    endclass

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   start       = 1'b0;
    logic                   busy;
    t_frame_in              i_frame     = '0;
    logic                   o_result_valid;
    t_frame_out             o_result;
    logic                   i_cap_we    = 1'b0;
    logic [CAP_CFG_W-1:0]   i_cap_wdata = '0;

    frame_fifo_predictor    predictor;
    int                     cycle_count = 0;

    stereo_audio_frame_fifo #(
        .DEPTH (DEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_frame        (i_frame),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cap_we       (i_cap_we),
        .i_cap_wdata    (i_cap_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog: a hang anywhere in the run ends it as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_stereo_audio_frame_fifo failed");
            $finish;
        end
    end

    // Monitor. At each rising edge the values read here are those of the cycle that
    // the edge ends, because the driver and the block both update with nonblocking
    // assignments. A capacity write is applied first, then an accepted item is
    // predicted, and only then is a result checked, so the order is fixed whatever
    // the latency of the block.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cap_we)
                predictor.set_capacity(i_cap_wdata);
            if (start && !busy)
                predictor.predict_frame(i_frame);
            if (o_result_valid === 1'b1)
                predictor.check_result(o_result);
            else if (o_result_valid !== 1'b0)
                predictor.note_failure("result strobe is unknown");
        end
    end

    function automatic t_frame_in make_frame(logic cmd, logic [15:0] left, logic [15:0] right,
                                             logic last);
        t_frame_in f;
        f.command          = cmd;
        f.left_sample      = left;
        f.right_sample     = right;
        f.last_of_transfer = last;
        return f;
    endfunction

    // Mostly uniform samples, with the full-scale values and zero mixed in often.
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 15))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    // Presents one item and returns at the edge that accepts it. Start is left high so
    // that a following item goes straight on; an idle stretch lowers it.
    task automatic send_frame(input t_frame_in f);
        start   <= 1'b1;
        i_frame <= f;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Idle cycles carry random content on the item port, which must be ignored.
    task automatic idle_cycles(input int n);
        if (n > 0) begin
            start   <= 1'b0;
            i_frame <= t_frame_in'($bits(t_frame_in)'({$urandom, $urandom}));
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Waits until every result has come back, then lets the pipeline settle.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (predictor.awaited_results.size() != 0) @(posedge i_clk);
        repeat (RESULT_LATENCY + 1) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_CFG_W-1:0] value);
        drain();
        i_cap_we    <= 1'b1;
        i_cap_wdata <= value;
        @(posedge i_clk);
        i_cap_we    <= 1'b0;
    endtask

    // Random transfers. Most are runs of pushes or of pops closed by a last item; some
    // mix both kinds, and a few carry random last flags so that transfers run on.
    task automatic run_transfers(input int n_items, input int idle_pct);
        int   sent;
        int   len;
        int   kind;
        int   gap;
        logic cmd;
        logic last;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 9);
            len  = $urandom_range(1, 12);
            for (int i = 0; i < len; i++) begin
                gap = 0;
                while ($urandom_range(0, 99) < idle_pct) gap++;
                idle_cycles(gap);
                if (kind < 4)
                    cmd = CMD_PUSH;
                else if (kind < 8)
                    cmd = CMD_POP;
                else
                    cmd = 1'($urandom_range(0, 1));
                last = (kind == 9) ? 1'($urandom_range(0, 1)) : (i == len - 1);
                send_frame(make_frame(cmd, pick_sample(), pick_sample(), last));
                sent++;
            end
        end
    endtask

    initial begin
        predictor = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset capacity. A pop from the empty queue opens the transfer with an
        // underflow, so the later pushes of the same transfer report queue full.
        send_frame(make_frame(CMD_POP,  16'h1111, 16'h2222, 1'b0));
        send_frame(make_frame(CMD_PUSH, 16'h8000, 16'h7fff, 1'b0));
        send_frame(make_frame(CMD_PUSH, 16'h7fff, 16'h8000, 1'b0));
        send_frame(make_frame(CMD_PUSH, 16'h0000, 16'h0000, 1'b0));
        send_frame(make_frame(CMD_PUSH, 16'hffff, 16'hffff, 1'b1));
        // A clean pop transfer returns the frames in order with status ok.
        send_frame(make_frame(CMD_POP,  16'hffff, 16'hffff, 1'b0));
        send_frame(make_frame(CMD_POP,  16'h0000, 16'h0000, 1'b0));
        send_frame(make_frame(CMD_POP,  16'h5555, 16'haaaa, 1'b0));
        send_frame(make_frame(CMD_POP,  16'haaaa, 16'h5555, 1'b1));
        // Leave a frame in the queue and the transfer open across a capacity write:
        // the queue must come back empty while the tallies carry on.
        send_frame(make_frame(CMD_PUSH, 16'h1234, 16'h5678, 1'b0));
        write_capacity(CAP_CFG_W'(1));
        send_frame(make_frame(CMD_POP,  16'h0000, 16'h0000, 1'b0));
        send_frame(make_frame(CMD_PUSH, 16'h4321, 16'h8765, 1'b0));
        send_frame(make_frame(CMD_PUSH, 16'h0f0f, 16'hf0f0, 1'b0));
        send_frame(make_frame(CMD_POP,  16'h0000, 16'h0000, 1'b0));
        send_frame(make_frame(CMD_POP,  16'h0000, 16'h0000, 1'b1));
        // A written capacity of zero behaves as one slot.
        write_capacity(CAP_CFG_W'(0));
        send_frame(make_frame(CMD_PUSH, 16'h00ff, 16'hff00, 1'b0));
        send_frame(make_frame(CMD_PUSH, 16'h0001, 16'hfffe, 1'b1));
        send_frame(make_frame(CMD_POP,  16'h0000, 16'h0000, 1'b1));

        // Oversized capacity clamps to the full depth: fill the ring to the brim and
        // push once more into the full queue. The write pointer wraps at the top of the
        // store on the way. A few pops then show that the oldest frames come out first.
        write_capacity(CAP_CFG_W'(2047));
        for (int i = 0; i <= DEPTH; i++)
            send_frame(make_frame(CMD_PUSH, pick_sample(), pick_sample(), i == DEPTH));
        for (int i = 0; i < 4; i++)
            send_frame(make_frame(CMD_POP, pick_sample(), pick_sample(), i == 3));

        // Random phases: a light sender gap, a heavy one, then back to back, each with
        // its own capacity. Small rings keep the full and empty edges busy.
        write_capacity(CAP_CFG_W'($urandom_range(2, 8)));
        run_transfers(135, 25);
        write_capacity(CAP_CFG_W'($urandom_range(1, 4)));
        run_transfers(135, 61);
        write_capacity(CAP_CFG_W'($urandom_range(9, DEPTH)));
        run_transfers(130, 0);

        drain();
        if (predictor.awaited_results.size() != 0)
            predictor.note_failure($sformatf("%0d results never arrived",
                                             predictor.awaited_results.size()));
        if (predictor.failures == 0)
            $display("tb_stereo_audio_frame_fifo passed");
        else
            $display("tb_stereo_audio_frame_fifo failed");
        $finish;
    end

endmodule
